// File: hw/rtl/cli_pkg.sv
package cli_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 32;
  localparam int unsigned MU_FRAC_BITS_DEF = 32;

  // Fixed-point width of the line parameters
  localparam int unsigned OUT_W = 48;

  localparam int unsigned HIT_W = 2;
  localparam logic [HIT_W-1:0] HIT_NONE    = 2'd0;
  localparam logic [HIT_W-1:0] HIT_TANGENT = 2'd1;
  localparam logic [HIT_W-1:0] HIT_TWO     = 2'd2;

endpackage

// File: hw/rtl/circle_line_intersection_unit.sv
// Circle / line intersection unit.
// Input: pulse start with the circle center, radius and the two line points;
// the item is taken at a clock edge with start high and busy low. busy is
// always low: a new item may enter every cycle.
// Output: done_o is high for exactly one cycle with hit_count_o (0 none or
// degenerate line, 1 tangent, 2 crossings), first_param_o, second_param_o
// (signed fixed point, MU_FRAC_BITS fraction bits) and clipped_o.
// The receiver cannot stall; results must be taken when done_o is high.
// Throughput: one item per cycle. The depth of the pipeline comes mostly
// from the square-root chain (one root bit per cell) and the two dividers
// (one quotient bit per cell) that follow it.
// Reset clears only the valid bits of the pipeline; no result comes out
// until an item has been taken after reset.
module circle_line_intersection_unit import cli_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int unsigned MU_FRAC_BITS = MU_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_WIDTH-1:0]  center_x_i,
  input  logic [COORD_WIDTH-1:0]  center_y_i,
  input  logic [COORD_WIDTH-2:0]  radius_i,
  input  logic [COORD_WIDTH-1:0]  start_x_i,
  input  logic [COORD_WIDTH-1:0]  start_y_i,
  input  logic [COORD_WIDTH-1:0]  end_x_i,
  input  logic [COORD_WIDTH-1:0]  end_y_i,
  output logic                    done_o,
  output logic [HIT_W-1:0]        hit_count_o,
  output logic signed [OUT_W-1:0] first_param_o,
  output logic signed [OUT_W-1:0] second_param_o,
  output logic                    clipped_o
);

  localparam int AW    = 2 * COORD_WIDTH + 1;
  localparam int HW    = 2 * COORD_WIDTH + 2;
  localparam int DSW   = 4 * COORD_WIDTH + 4;
  localparam int RW    = 2 * COORD_WIDTH + 2 + MU_FRAC_BITS;
  localparam int NSW   = 2 * COORD_WIDTH + 4 + MU_FRAC_BITS;
  localparam int NMW   = NSW - 1;
  localparam int STW   = AW + OUT_W;
  localparam int SQ_SW = HIT_W + AW + HW + DSW;
  localparam int DV_SW = HIT_W + 4;

  assign busy = 1'b0;

  // quadratic and discriminant
  logic                  q_vld;
  logic [AW-1:0]         q_a;
  logic signed [HW-1:0]  q_h;
  logic signed [DSW-1:0] q_d;

  cli_quad #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_quad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .valid_o    (q_vld),
    .a_o        (q_a),
    .h_o        (q_h),
    .d_o        (q_d)
  );

  logic [HIT_W-1:0] hit0;
  logic [DSW-1:0]   rad0;

  always_comb begin
    if (q_a == '0) begin
      hit0 = HIT_NONE;
    end else if (q_d == '0) begin
      hit0 = HIT_TANGENT;
    end else if (q_d[DSW-1]) begin
      hit0 = HIT_NONE;
    end else begin
      hit0 = HIT_TWO;
    end
  end

  // feed zero to the root when the discriminant is negative
  assign rad0 = q_d[DSW-1] ? '0 : q_d;

  // square-root chain
  logic             sq_vld  [RW+1];
  logic [RW:0]      sq_rem  [RW+1];
  logic [RW-1:0]    sq_root [RW+1];
  logic [SQ_SW-1:0] sq_side [RW+1];

  assign sq_vld[0]  = q_vld;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {hit0, q_a, q_h, rad0};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [1:0] pair;
    if (DSW - 2 - 2 * k >= 0) begin : g_bits
      assign pair = sq_side[k][DSW-1-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    cli_sqrt_cell #(
      .RW     (RW),
      .SIDE_W (SQ_SW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .pair_i  (pair),
      .side_i  (sq_side[k]),
      .valid_o (sq_vld[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // numerators -h*2^F +/- root
  logic [HIT_W-1:0]      e_hit;
  logic [AW-1:0]         e_a;
  logic signed [HW-1:0]  e_h;
  logic signed [NSW-1:0] e_hx, e_hs, e_root;
  logic signed [NSW-1:0] n1_d, n2_d, n1_q, n2_q;
  logic                  c1_vld_q, c2_vld_q, c3_vld_q;
  logic [HIT_W-1:0]      c1_hit_q, c2_hit_q, c3_hit_q;
  logic [AW-1:0]         c1_a_q, c2_a_q, c3_a_q;

  assign e_hit  = sq_side[RW][DSW+HW+AW +: HIT_W];
  assign e_a    = sq_side[RW][DSW+HW +: AW];
  assign e_h    = sq_side[RW][DSW +: HW];
  assign e_hx   = e_h;
  assign e_hs   = -(e_hx <<< MU_FRAC_BITS);
  assign e_root = $signed(NSW'(sq_root[RW]));
  assign n1_d   = e_hs + e_root;
  assign n2_d   = e_hs - e_root;

  // magnitudes and signs
  logic [NSW-1:0] n1_abs, n2_abs;
  logic [NMW-1:0] m1_q, m2_q;
  logic           s1_q, s2_q, s1c_q, s2c_q;

  assign n1_abs = n1_q[NSW-1] ? NSW'(-n1_q) : NSW'(n1_q);
  assign n2_abs = n2_q[NSW-1] ? NSW'(-n2_q) : NSW'(n2_q);

  // overflow test and divider load
  logic [STW-1:0] x1, x2, st1_q, st2_q;
  logic           ov1_d, ov2_d, ov1_q, ov2_q;

  assign x1    = STW'(m1_q);
  assign x2    = STW'(m2_q);
  assign ov1_d = x1[STW-1:OUT_W] >= c2_a_q;
  assign ov2_d = x2[STW-1:OUT_W] >= c2_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      c2_vld_q <= 1'b0;
      c3_vld_q <= 1'b0;
    end else begin
      c1_vld_q <= sq_vld[RW];
      c2_vld_q <= c1_vld_q;
      c3_vld_q <= c2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q     <= n1_d;
    n2_q     <= n2_d;
    c1_hit_q <= e_hit;
    c1_a_q   <= e_a;
    m1_q     <= n1_abs[NMW-1:0];
    m2_q     <= n2_abs[NMW-1:0];
    s1_q     <= n1_q[NSW-1];
    s2_q     <= n2_q[NSW-1];
    c2_hit_q <= c1_hit_q;
    c2_a_q   <= c1_a_q;
    st1_q    <= x1;
    st2_q    <= x2;
    ov1_q    <= ov1_d;
    ov2_q    <= ov2_d;
    s1c_q    <= s1_q;
    s2c_q    <= s2_q;
    c3_hit_q <= c2_hit_q;
    c3_a_q   <= c2_a_q;
  end

  // divider chain
  logic             dv_vld  [OUT_W+1];
  logic [AW-1:0]    dv_a    [OUT_W+1];
  logic [STW-1:0]   dv_st1  [OUT_W+1];
  logic [STW-1:0]   dv_st2  [OUT_W+1];
  logic [DV_SW-1:0] dv_side [OUT_W+1];

  assign dv_vld[0]  = c3_vld_q;
  assign dv_a[0]    = c3_a_q;
  assign dv_st1[0]  = st1_q;
  assign dv_st2[0]  = st2_q;
  assign dv_side[0] = {c3_hit_q, s1c_q, s2c_q, ov1_q, ov2_q};

  for (genvar j = 0; j < OUT_W; j++) begin : g_div
    cli_div_cell #(
      .AW     (AW),
      .SIDE_W (DV_SW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_vld[j]),
      .a_i     (dv_a[j]),
      .st1_i   (dv_st1[j]),
      .st2_i   (dv_st2[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_vld[j+1]),
      .a_o     (dv_a[j+1]),
      .st1_o   (dv_st1[j+1]),
      .st2_o   (dv_st2[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // saturate and select
  localparam logic [OUT_W-1:0] MAX_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] MIN_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  logic [HIT_W-1:0] f_hit;
  logic             f_s1, f_s2, f_ov1, f_ov2, clip1, clip2;
  logic [OUT_W-1:0] q1, q2, v1, v2;
  logic             done_q;
  logic [HIT_W-1:0] hit_d, hit_q;
  logic [OUT_W-1:0] first_d, first_q, second_d, second_q;
  logic             clip_d, clip_q;

  assign {f_hit, f_s1, f_s2, f_ov1, f_ov2} = dv_side[OUT_W];
  assign q1 = dv_st1[OUT_W][OUT_W-1:0];
  assign q2 = dv_st2[OUT_W][OUT_W-1:0];

  always_comb begin
    if (f_s1) begin
      clip1 = f_ov1 | (q1[OUT_W-1] & (|q1[OUT_W-2:0]));
      v1    = clip1 ? MIN_NEG : -q1;
    end else begin
      clip1 = f_ov1 | q1[OUT_W-1];
      v1    = clip1 ? MAX_POS : q1;
    end
    if (f_s2) begin
      clip2 = f_ov2 | (q2[OUT_W-1] & (|q2[OUT_W-2:0]));
      v2    = clip2 ? MIN_NEG : -q2;
    end else begin
      clip2 = f_ov2 | q2[OUT_W-1];
      v2    = clip2 ? MAX_POS : q2;
    end

    case (f_hit)
      HIT_TANGENT: begin
        hit_d    = HIT_TANGENT;
        first_d  = v1;
        second_d = '0;
        clip_d   = clip1;
      end
      HIT_TWO: begin
        hit_d    = HIT_TWO;
        first_d  = v1;
        second_d = v2;
        clip_d   = clip1 | clip2;
      end
      default: begin
        hit_d    = HIT_NONE;
        first_d  = '0;
        second_d = '0;
        clip_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld[OUT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    first_q  <= first_d;
    second_q <= second_d;
    clip_q   <= clip_d;
  end

  assign done_o         = done_q;
  assign hit_count_o    = hit_q;
  assign first_param_o  = first_q;
  assign second_param_o = second_q;
  assign clipped_o      = clip_q;

endmodule

// File: hw/rtl/cli_quad.sv
module cli_quad import cli_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [COORD_WIDTH-1:0]        center_x_i,
  input  logic [COORD_WIDTH-1:0]        center_y_i,
  input  logic [COORD_WIDTH-2:0]        radius_i,
  input  logic [COORD_WIDTH-1:0]        start_x_i,
  input  logic [COORD_WIDTH-1:0]        start_y_i,
  input  logic [COORD_WIDTH-1:0]        end_x_i,
  input  logic [COORD_WIDTH-1:0]        end_y_i,
  output logic                          valid_o,
  output logic [2*COORD_WIDTH:0]        a_o,
  output logic signed [2*COORD_WIDTH+1:0] h_o,
  output logic signed [4*COORD_WIDTH+3:0] d_o
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW2 = 2 * DW;
  localparam int AW  = 2 * COORD_WIDTH + 1;
  localparam int HW  = 2 * COORD_WIDTH + 2;
  localparam int SPL = COORD_WIDTH + 1;
  localparam int PPW = 2 * SPL + 2;
  localparam int DSW = 4 * COORD_WIDTH + 4;

  logic [5:0] vld_q, vld_d;

  // stage 1: differences
  logic signed [DW-1:0] dx_d, dy_d, ux_d, uy_d, dx_q, dy_q, ux_q, uy_q;
  logic [COORD_WIDTH-2:0] rad_q;

  assign dx_d = $signed({end_x_i[COORD_WIDTH-1], end_x_i})
              - $signed({start_x_i[COORD_WIDTH-1], start_x_i});
  assign dy_d = $signed({end_y_i[COORD_WIDTH-1], end_y_i})
              - $signed({start_y_i[COORD_WIDTH-1], start_y_i});
  assign ux_d = $signed({start_x_i[COORD_WIDTH-1], start_x_i})
              - $signed({center_x_i[COORD_WIDTH-1], center_x_i});
  assign uy_d = $signed({start_y_i[COORD_WIDTH-1], start_y_i})
              - $signed({center_y_i[COORD_WIDTH-1], center_y_i});

  // stage 2: products
  logic signed [PW2-1:0] dx_e, dy_e, ux_e, uy_e;
  logic signed [PW2-1:0] sq_dx_d, sq_dy_d, dot_x_d, dot_y_d, sq_ux_d, sq_uy_d;
  logic signed [PW2-1:0] sq_dx_q, sq_dy_q, dot_x_q, dot_y_q, sq_ux_q, sq_uy_q;
  logic [PW2-1:0] rr_d, rr_q;

  assign dx_e = dx_q;
  assign dy_e = dy_q;
  assign ux_e = ux_q;
  assign uy_e = uy_q;
  assign sq_dx_d = dx_e * dx_e;
  assign sq_dy_d = dy_e * dy_e;
  assign dot_x_d = dx_e * ux_e;
  assign dot_y_d = dy_e * uy_e;
  assign sq_ux_d = ux_e * ux_e;
  assign sq_uy_d = uy_e * uy_e;
  assign rr_d    = PW2'(rad_q) * PW2'(rad_q);

  // stage 3: quadratic terms
  logic signed [PW2-1:0] asum;
  logic [AW-1:0] a3_d, a3_q, a4_q, a5_q, a6_q;
  logic signed [HW-1:0] h3_d, h3_q, h4_q, h5_q, h6_q, c3_d, c3_q;

  assign asum = sq_dx_q + sq_dy_q;
  assign a3_d = asum[AW-1:0];
  assign h3_d = dot_x_q + dot_y_q;
  assign c3_d = sq_ux_q + sq_uy_q - $signed(rr_q);

  // stage 4: split h*h and a*c into partial products
  logic [SPL-1:0] hl, al, cl;
  logic signed [HW-SPL-1:0] hh, ch;
  logic [AW-SPL-1:0] ah;
  logic signed [PPW-1:0] hl_e, hh_e, al_e, ah_e, cl_e, ch_e;
  logic signed [PPW-1:0] hh2_d, hhl_d, hl2_d, ahch_d, ahcl_d, alch_d, alcl_d;
  logic signed [PPW-1:0] hh2_q, hhl_q, hl2_q, ahch_q, ahcl_q, alch_q, alcl_q;

  assign hl = h3_q[SPL-1:0];
  assign hh = h3_q[HW-1:SPL];
  assign al = a3_q[SPL-1:0];
  assign ah = a3_q[AW-1:SPL];
  assign cl = c3_q[SPL-1:0];
  assign ch = c3_q[HW-1:SPL];
  assign hl_e = $signed({1'b0, hl});
  assign hh_e = hh;
  assign al_e = $signed({1'b0, al});
  assign ah_e = $signed({1'b0, ah});
  assign cl_e = $signed({1'b0, cl});
  assign ch_e = ch;
  assign hh2_d  = hh_e * hh_e;
  assign hhl_d  = hh_e * hl_e;
  assign hl2_d  = hl_e * hl_e;
  assign ahch_d = ah_e * ch_e;
  assign ahcl_d = ah_e * cl_e;
  assign alch_d = al_e * ch_e;
  assign alcl_d = al_e * cl_e;

  // stage 5: recombine, stage 6: discriminant
  logic signed [DSW-1:0] hh2_w, hhl_w, hl2_w, ahch_w, ahcl_w, alch_w, alcl_w;
  logic signed [DSW-1:0] h2_d, h2_q, ac_d, ac_q, d_d, d_q;

  assign hh2_w  = hh2_q;
  assign hhl_w  = hhl_q;
  assign hl2_w  = hl2_q;
  assign ahch_w = ahch_q;
  assign ahcl_w = ahcl_q;
  assign alch_w = alch_q;
  assign alcl_w = alcl_q;
  assign h2_d = (hh2_w <<< (2 * SPL)) + (hhl_w <<< (SPL + 1)) + hl2_w;
  assign ac_d = (ahch_w <<< (2 * SPL)) + ((ahcl_w + alch_w) <<< SPL) + alcl_w;
  assign d_d  = h2_q - ac_q;

  assign vld_d = {vld_q[4:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    ux_q    <= ux_d;
    uy_q    <= uy_d;
    rad_q   <= radius_i;
    sq_dx_q <= sq_dx_d;
    sq_dy_q <= sq_dy_d;
    dot_x_q <= dot_x_d;
    dot_y_q <= dot_y_d;
    sq_ux_q <= sq_ux_d;
    sq_uy_q <= sq_uy_d;
    rr_q    <= rr_d;
    a3_q    <= a3_d;
    h3_q    <= h3_d;
    c3_q    <= c3_d;
    hh2_q   <= hh2_d;
    hhl_q   <= hhl_d;
    hl2_q   <= hl2_d;
    ahch_q  <= ahch_d;
    ahcl_q  <= ahcl_d;
    alch_q  <= alch_d;
    alcl_q  <= alcl_d;
    a4_q    <= a3_q;
    h4_q    <= h3_q;
    h2_q    <= h2_d;
    ac_q    <= ac_d;
    a5_q    <= a4_q;
    h5_q    <= h4_q;
    d_q     <= d_d;
    a6_q    <= a5_q;
    h6_q    <= h5_q;
  end

  assign valid_o = vld_q[5];
  assign a_o     = a6_q;
  assign h_o     = h6_q;
  assign d_o     = d_q;

endmodule

// File: hw/rtl/cli_sqrt_cell.sv
module cli_sqrt_cell import cli_pkg::*; #(
  parameter int unsigned RW     = 98,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RW:0]       rem_i,
  input  logic [RW-1:0]     root_i,
  input  logic [1:0]        pair_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RW:0]       rem_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [RW+2:0] rem_x, trial, diff;
  logic          ge;
  logic          valid_q;
  logic [RW:0]   rem_d, rem_q;
  logic [RW-1:0] root_d, root_q;
  logic [SIDE_W-1:0] side_q;

  // one root bit: bring down two radicand bits, try 4*root+1
  assign rem_x  = {rem_i, pair_i};
  assign trial  = {1'b0, root_i, 2'b01};
  assign ge     = rem_x >= trial;
  assign diff   = rem_x - trial;
  assign rem_d  = ge ? diff[RW:0] : rem_x[RW:0];
  assign root_d = {root_i[RW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// File: hw/rtl/cli_div_cell.sv
module cli_div_cell import cli_pkg::*; #(
  parameter int unsigned AW     = 65,
  parameter int unsigned SIDE_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [AW-1:0]       a_i,
  input  logic [AW+OUT_W-1:0] st1_i,
  input  logic [AW+OUT_W-1:0] st2_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [AW-1:0]       a_o,
  output logic [AW+OUT_W-1:0] st1_o,
  output logic [AW+OUT_W-1:0] st2_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic [AW:0] top1, top2, dif1, dif2, a_x;
  logic        ge1, ge2;
  logic        valid_q;
  logic [AW-1:0] a_q;
  logic [AW+OUT_W-1:0] st1_d, st2_d, st1_q, st2_q;
  logic [SIDE_W-1:0] side_q;

  // remainder sits on top, numerator bits shift up, quotient bits enter below
  assign a_x  = {1'b0, a_i};
  assign top1 = st1_i[AW+OUT_W-1:OUT_W-1];
  assign top2 = st2_i[AW+OUT_W-1:OUT_W-1];
  assign ge1  = top1 >= a_x;
  assign ge2  = top2 >= a_x;
  assign dif1 = top1 - a_x;
  assign dif2 = top2 - a_x;
  assign st1_d = {(ge1 ? dif1[AW-1:0] : top1[AW-1:0]), st1_i[OUT_W-2:0], ge1};
  assign st2_d = {(ge2 ? dif2[AW-1:0] : top2[AW-1:0]), st2_i[OUT_W-2:0], ge2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    st1_q  <= st1_d;
    st2_q  <= st2_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign st1_o   = st1_q;
  assign st2_o   = st2_q;
  assign side_o  = side_q;

endmodule
